[hw/rtl/terminal_line_editor_macros.svh]
// Assertion macros shared by the terminal line editor RTL.
`ifndef TERMINAL_LINE_EDITOR_MACROS_SVH
`define TERMINAL_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/tle_pkg.sv]
// Shared types, codes and helper functions of the terminal line editor.
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

   // Geometry and field widths
   localparam int LINE_MAX_DEF = 32;
   localparam int CAP_W        = 6;
   localparam int TMO_W        = 16;
   localparam int TICK_W       = 17;
   localparam int CMD_W        = 2;
   localparam int BYTE_W       = 8;
   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int PEND_W       = 2;
   localparam int ECHO_IDX_W   = 2;

   localparam logic [TICK_W-1:0] TICK_SAT = '1;

   // Input commands
   localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DISCARD = 2'd2;

   // Remembered end-of-line byte
   localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
   localparam logic [PEND_W-1:0] PEND_CR   = 2'd1;
   localparam logic [PEND_W-1:0] PEND_LF   = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

   // End marker status
   localparam logic [STATUS_W-1:0] STAT_NONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_COMPLETE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_CANCEL   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_TIMEOUT  = 2'd3;

   // Character codes
   localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
   localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
   localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
   localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

   // Echo sequences
   typedef enum logic [1:0] {
      ECHO_CHAR,
      ECHO_CRLF,
      ECHO_CTRLC,
      ECHO_ERASE
   } echo_kind_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                  take;
      logic                  pend_wr;
      logic [PEND_W-1:0]     pend_val;
      logic                  store_wr;
      logic                  count_dec;
      logic                  tick;
      logic                  line_clear;
      logic                  ptr_clr;
      logic                  ptr_inc;
      logic                  out_load;
      logic [KIND_W-1:0]     out_kind;
      echo_kind_type         echo_kind;
      logic [ECHO_IDX_W-1:0] echo_idx;
      logic [STATUS_W-1:0]   out_status;
      logic                  out_last;
   } tle_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic              is_cr;
      logic              is_lf;
      logic              is_etx;
      logic              is_erase;
      logic              is_print;
      logic [PEND_W-1:0] pend;
      logic              count_zero;
      logic              room;
      logic              expire;
      logic              out_free;
      logic              strm_last;
   } tle_stat_type;

   // Byte at position idx of an echo sequence
   function automatic logic [BYTE_W-1:0] echo_byte(echo_kind_type kind,
                                                   logic [ECHO_IDX_W-1:0] idx,
                                                   logic [BYTE_W-1:0] ch);
      logic [BYTE_W-1:0] r;
      r = ch;
      case (kind)
         ECHO_CHAR:  r = ch;
         ECHO_CRLF:  r = (idx == 2'd0) ? CH_CR : CH_LF;
         ECHO_CTRLC: begin
            case (idx)
               2'd0:    r = CH_CARET;
               2'd1:    r = CH_C;
               2'd2:    r = CH_CR;
               default: r = CH_LF;
            endcase
         end
         ECHO_ERASE: r = (idx == 2'd1) ? CH_SPACE : CH_BS;
         default:    r = ch;
      endcase
      return r;
   endfunction

   // Index of the final byte of an echo sequence
   function automatic logic [ECHO_IDX_W-1:0] echo_last(echo_kind_type kind);
      logic [ECHO_IDX_W-1:0] r;
      r = 2'd0;
      case (kind)
         ECHO_CHAR:  r = 2'd0;
         ECHO_CRLF:  r = 2'd1;
         ECHO_CTRLC: r = 2'd3;
         ECHO_ERASE: r = 2'd2;
         default:    r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/tle_channels.sv]
// Handshake channel interfaces for input commands and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface tle_req_if import tle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface tle_rsp_if import tle_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [BYTE_W-1:0]   data;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output kind, output data, output status,
                   output last, input ready);
   modport sink   (input valid, input kind, input data, input status,
                   input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/tle_ctrl.sv]
// Sequencing state machine of the terminal line editor.
`timescale 1ns / 1ps
`default_nettype none

module tle_ctrl import tle_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [CMD_W-1:0] req_command,
   output      logic             req_ready,
   input  wire tle_stat_type     stat,
   output      tle_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ECHO,
      S_STRM_RD,
      S_STRM_OUT,
      S_END
   } state_type;

   typedef enum logic [1:0] {
      AFTER_DONE,
      AFTER_STREAM,
      AFTER_END
   } after_type;

   state_type             state_ff, state_in;
   echo_kind_type         echo_kind_ff, echo_kind_in;
   logic [ECHO_IDX_W-1:0] echo_idx_ff, echo_idx_in;
   after_type             after_ff, after_in;
   logic [STATUS_W-1:0]   end_status_ff, end_status_in;
   logic                  echo_done;

   assign req_ready = (state_ff == S_IDLE);
   assign echo_done = (echo_idx_ff == echo_last(echo_kind_ff));

   // Decide commands and next state
   always_comb begin
      state_in      = state_ff;
      echo_kind_in  = echo_kind_ff;
      echo_idx_in   = echo_idx_ff;
      after_in      = after_ff;
      end_status_in = end_status_ff;

      cmd            = '0;
      cmd.take       = req_valid && req_ready;
      cmd.pend_val   = PEND_NONE;
      cmd.out_kind   = KIND_ECHO;
      cmd.echo_kind  = echo_kind_ff;
      cmd.echo_idx   = echo_idx_ff;
      cmd.out_status = STAT_NONE;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.take) begin
               echo_idx_in = '0;
               case (req_command)
                  CMD_BYTE: begin
                     // Any byte rewrites the remembered end of line; only an unpaired CR or LF sets it
                     cmd.pend_wr = 1'b1;
                     if ((stat.pend == PEND_CR && stat.is_lf) ||
                         (stat.pend == PEND_LF && stat.is_cr)) begin
                        cmd.pend_val = PEND_NONE;
                     end else if (stat.is_cr || stat.is_lf) begin
                        cmd.pend_val  = stat.is_cr ? PEND_CR : PEND_LF;
                        cmd.ptr_clr   = 1'b1;
                        echo_kind_in  = ECHO_CRLF;
                        after_in      = AFTER_STREAM;
                        end_status_in = STAT_COMPLETE;
                        state_in      = S_ECHO;
                     end else if (stat.is_etx) begin
                        echo_kind_in  = ECHO_CTRLC;
                        after_in      = AFTER_END;
                        end_status_in = STAT_CANCEL;
                        state_in      = S_ECHO;
                     end else if (stat.is_erase) begin
                        if (!stat.count_zero) begin
                           cmd.count_dec = 1'b1;
                           echo_kind_in  = ECHO_ERASE;
                           after_in      = AFTER_DONE;
                           state_in      = S_ECHO;
                        end
                     end else if (stat.is_print && stat.room) begin
                        cmd.store_wr = 1'b1;
                        echo_kind_in = ECHO_CHAR;
                        after_in     = AFTER_DONE;
                        state_in     = S_ECHO;
                     end
                  end
                  CMD_TICK: begin
                     cmd.tick = 1'b1;
                     if (stat.expire) begin
                        cmd.ptr_clr   = 1'b1;
                        end_status_in = STAT_TIMEOUT;
                        state_in      = stat.count_zero ? S_END : S_STRM_RD;
                     end
                  end
                  CMD_DISCARD: begin
                     cmd.pend_wr = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_ECHO: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = echo_done && (after_ff == AFTER_DONE);
               if (echo_done) begin
                  case (after_ff)
                     AFTER_STREAM: state_in = stat.count_zero ? S_END : S_STRM_RD;
                     AFTER_END:    state_in = S_END;
                     default:      state_in = S_IDLE;
                  endcase
               end else begin
                  echo_idx_in = echo_idx_ff + 2'd1;
               end
            end
         end
         S_STRM_RD: begin
            // Let the line memory read settle
            state_in = S_STRM_OUT;
         end
         S_STRM_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_CHAR;
               cmd.ptr_inc  = 1'b1;
               state_in     = stat.strm_last ? S_END : S_STRM_RD;
            end
         end
         S_END: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = KIND_END;
               cmd.out_status = end_status_ff;
               cmd.out_last   = 1'b1;
               cmd.line_clear = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and sequence registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         echo_kind_ff  <= ECHO_CHAR;
         echo_idx_ff   <= '0;
         after_ff      <= AFTER_DONE;
         end_status_ff <= STAT_NONE;
      end else begin
         state_ff      <= state_in;
         echo_kind_ff  <= echo_kind_in;
         echo_idx_ff   <= echo_idx_in;
         after_ff      <= after_in;
         end_status_ff <= end_status_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/tle_datapath.sv]
// Line memory, counters and result register of the terminal line editor.
`timescale 1ns / 1ps
`default_nettype none

module tle_datapath import tle_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [CAP_W-1:0]    line_capacity,
   input  wire logic [TMO_W-1:0]    timeout_ticks,
   input  wire logic [BYTE_W-1:0]   req_rx_byte,
   input  wire tle_cmd_type         cmd,
   output      tle_stat_type        stat,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [KIND_W-1:0]   rsp_kind,
   output      logic [BYTE_W-1:0]   rsp_data,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic                rsp_last
);

   localparam int CW = $clog2(LINE_MAX);
   localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(LINE_MAX);

   logic [BYTE_W-1:0]   line_mem [LINE_MAX];
   logic [BYTE_W-1:0]   rd_data_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [PEND_W-1:0]   pend_ff, pend_in;
   logic [TICK_W-1:0]   elapsed_ff, elapsed_in, elapsed_inc;
   logic [BYTE_W-1:0]   rx_ff, rx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [CAP_W-1:0]    cap_clamp, keep_limit;

   // Clamp capacity and derive how many characters fit
   always_comb begin
      cap_clamp  = (line_capacity > CAP_MAX) ? CAP_MAX : line_capacity;
      keep_limit = (cap_clamp == '0) ? '0 : cap_clamp - CAP_W'(1);
   end

   // Saturating tick count
   assign elapsed_inc = (elapsed_ff == TICK_SAT) ? elapsed_ff
                                                 : elapsed_ff + TICK_W'(1);

   // Report byte class and line state
   always_comb begin
      stat.is_cr      = (req_rx_byte == CH_CR);
      stat.is_lf      = (req_rx_byte == CH_LF);
      stat.is_etx     = (req_rx_byte == CH_ETX);
      stat.is_erase   = (req_rx_byte == CH_BS) || (req_rx_byte == CH_DEL);
      stat.is_print   = (req_rx_byte >= CH_SPACE) && (req_rx_byte < CH_DEL);
      stat.pend       = pend_ff;
      stat.count_zero = (count_ff == '0);
      stat.room       = CAP_W'(count_ff) < keep_limit;
      stat.expire     = (timeout_ticks != '0) && (elapsed_inc > TICK_W'(timeout_ticks));
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      stat.strm_last  = ((CW+1)'(ptr_ff) + (CW+1)'(1)) == (CW+1)'(count_ff);
   end

   // Advance counters and capture the received byte
   always_comb begin
      count_in = count_ff;
      if (cmd.line_clear) begin
         count_in = '0;
      end else if (cmd.store_wr) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end

      elapsed_in = elapsed_ff;
      if (cmd.line_clear) begin
         elapsed_in = '0;
      end else if (cmd.tick) begin
         elapsed_in = elapsed_inc;
      end

      pend_in = cmd.pend_wr ? cmd.pend_val : pend_ff;

      ptr_in = ptr_ff;
      if (cmd.ptr_clr) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CW'(1);
      end

      rx_in = cmd.take ? req_rx_byte : rx_ff;
   end

   // Load the result register when it frees up
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = cmd.out_kind;
         rsp_status_in = cmd.out_status;
         rsp_last_in   = cmd.out_last;
         case (cmd.out_kind)
            KIND_ECHO: rsp_data_in = echo_byte(cmd.echo_kind, cmd.echo_idx, rx_ff);
            KIND_CHAR: rsp_data_in = rd_data_ff;
            default:   rsp_data_in = '0;
         endcase
      end
   end

   // Line memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         line_mem[count_ff] <= req_rx_byte;
      end
      rd_data_ff <= line_mem[ptr_ff];
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= PEND_NONE;
         elapsed_ff   <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         elapsed_ff   <= elapsed_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      rx_ff         <= rx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

[hw/rtl/terminal_line_editor.sv]
// Terminal line editor: canonical-mode line discipline with echo, erase, cancel and timeout.
// Takes one command beat at a time: a received byte, a time tick or a discard of the
// remembered end-of-line byte. A command that causes no result leaves the block idle.
// A byte with an echo then sends its echo beats: a printable byte its single echo, or the
// erase, CR LF or ^C CR LF sequence. A line end or timeout additionally streams the stored
// line, each character waiting on the registered read of the line memory, then the end
// marker. Results wait in an output register; a stalled result consumer holds the sequence.
// Configuration is to be written through the APB port only while the block is idle; the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "terminal_line_editor_macros.svh"

module terminal_line_editor import tle_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tle_req_if.sink          req,
   tle_rsp_if.source        rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_TIMEOUT  = 1'b1;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

   logic [CAP_W-1:0] capacity_ff;
   logic [TMO_W-1:0] timeout_ff;
   logic             csr_wr;
   tle_cmd_type      cmd;
   tle_stat_type     stat;

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         timeout_ff  <= '0;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_CAPACITY: capacity_ff <= pwdata[CAP_W-1:0];
            REG_TIMEOUT:  timeout_ff  <= pwdata[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_CAPACITY: prdata = 32'(capacity_ff);
         REG_TIMEOUT:  prdata = 32'(timeout_ff);
         default:      prdata = '0;
      endcase
   end

   // Sequencer
   tle_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_command (req.command),
      .req_ready   (req.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // Line memory and result register
   tle_datapath #(
      .LINE_MAX (LINE_MAX)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .line_capacity (capacity_ff),
      .timeout_ticks (timeout_ff),
      .req_rx_byte   (req.rx_byte),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_kind      (rsp.kind),
      .rsp_data      (rsp.data),
      .rsp_status    (rsp.status),
      .rsp_last      (rsp.last)
   );

   // End marker closes the beat sequence with a real status
   `TLE_ASSERT_IMP(a_end_marker, clock, reset, rsp.valid && rsp.kind == KIND_END, rsp.last && rsp.status != STAT_NONE && rsp.data == '0, "end marker malformed")
   // Echo and line beats carry no status
   `TLE_ASSERT_IMP(a_body_status, clock, reset, rsp.valid && rsp.kind != KIND_END, rsp.status == STAT_NONE, "status on non-end beat")
   // A stored character is never the final beat
   `TLE_ASSERT_IMP(a_char_not_last, clock, reset, rsp.valid && rsp.kind == KIND_CHAR, !rsp.last, "line character flagged last")
   // Ending a line empties the store
   `TLE_ASSERT_NXT(a_end_clears, clock, reset, cmd.out_load && cmd.out_kind == KIND_END, stat.count_zero, "line not cleared after end")

endmodule

`default_nettype wire
